/* src/ucfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucfd_pkg
// Shared types, constants and helpers of the UART command frame detector.
// ----------------------------------------------------------------------------
package ucfd_pkg;

	// receive buffer depth and derived widths
	localparam int RX_BUFFER_DEPTH = 4096;
	localparam int POS_W           = $clog2(RX_BUFFER_DEPTH);
	localparam int FIELD_W         = 12;
	localparam int PLEN_W          = 16;
	localparam int CMP_W           = ((POS_W > PLEN_W) ? POS_W : PLEN_W) + 1;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [PLEN_W-1:0]  plen_t;

	// frame end decision for one stored byte
	typedef struct packed {
		logic frame_end;
		logic bad_command;
		logic name_done;
	} rule_res_t;

	// command codes
	localparam logic [7:0] CMD_X01 = 8'h01;
	localparam logic [7:0] CMD_X02 = 8'h02;
	localparam logic [7:0] CMD_X03 = 8'h03;
	localparam logic [7:0] CMD_X08 = 8'h08;
	localparam logic [7:0] CMD_X0C = 8'h0C;
	localparam logic [7:0] CMD_X0E = 8'h0E;
	localparam logic [7:0] CMD_X10 = 8'h10;
	localparam logic [7:0] CMD_X11 = 8'h11;
	localparam logic [7:0] CMD_X12 = 8'h12;
	localparam logic [7:0] CMD_X13 = 8'h13;
	localparam logic [7:0] CMD_X14 = 8'h14;
	localparam logic [7:0] CMD_X15 = 8'h15;
	localparam logic [7:0] CMD_X16 = 8'h16;
	localparam logic [7:0] CMD_X17 = 8'h17;
	localparam logic [7:0] CMD_X18 = 8'h18;
	localparam logic [7:0] CMD_X19 = 8'h19;
	localparam logic [7:0] CMD_X1A = 8'h1A;
	localparam logic [7:0] CMD_X1B = 8'h1B;
	localparam logic [7:0] CMD_X1C = 8'h1C;
	localparam logic [7:0] CMD_X1D = 8'h1D;
	localparam logic [7:0] CMD_X1E = 8'h1E;
	localparam logic [7:0] CMD_X1F = 8'h1F;
	localparam logic [7:0] CMD_X20 = 8'h20;
	localparam logic [7:0] CMD_X21 = 8'h21;
	localparam logic [7:0] CMD_X22 = 8'h22;
	localparam logic [7:0] CMD_X40 = 8'h40;

	// operation codes
	localparam logic OP_DATA    = 1'b0;
	localparam logic OP_CONTROL = 1'b1;

	// control value bit that clears the frame
	localparam int CLEAR_BIT = 7;

	// map an internal position onto the 12 bit result field
	function automatic field_t to_field(pos_t p);
		logic [POS_W+FIELD_W-1:0] ext;
		ext = {{FIELD_W{1'b0}}, p};
		return ext[FIELD_W-1:0];
	endfunction

endpackage

/* src/ucfd_rules.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucfd_rules
// Per-command frame end rules, evaluated on the count after a stored byte.
// ----------------------------------------------------------------------------
module ucfd_rules (
	input  logic [7:0]          code,
	input  ucfd_pkg::pos_t      n,
	input  logic [7:0]          byte_in,
	input  ucfd_pkg::plen_t     plen,
	input  logic                name_done,
	output ucfd_pkg::rule_res_t res
);

	logic                       zero_b;
	logic [ucfd_pkg::CMP_W-1:0] n_ext;
	logic [ucfd_pkg::CMP_W-1:0] write_end;

	assign zero_b    = (byte_in == 8'h00);
	assign n_ext     = ucfd_pkg::CMP_W'(n);
	assign write_end = ucfd_pkg::CMP_W'(plen) + ucfd_pkg::CMP_W'(4);

	// code decoder
	always_comb begin
		res.frame_end   = 1'b0;
		res.bad_command = 1'b0;
		res.name_done   = name_done;
		unique case (code) inside
			ucfd_pkg::CMD_X01, ucfd_pkg::CMD_X02, ucfd_pkg::CMD_X0C,
			ucfd_pkg::CMD_X1E, ucfd_pkg::CMD_X1F: begin
				res.frame_end = 1'b1;
			end
			ucfd_pkg::CMD_X03, ucfd_pkg::CMD_X08, ucfd_pkg::CMD_X0E,
			ucfd_pkg::CMD_X11, ucfd_pkg::CMD_X15, ucfd_pkg::CMD_X17,
			ucfd_pkg::CMD_X18: begin
				res.frame_end = (n == ucfd_pkg::POS_W'(2));
			end
			ucfd_pkg::CMD_X12, ucfd_pkg::CMD_X21: begin
				res.frame_end = (n == ucfd_pkg::POS_W'(4));
			end
			ucfd_pkg::CMD_X14: begin
				res.frame_end = (n == ucfd_pkg::POS_W'(6));
			end
			ucfd_pkg::CMD_X16, ucfd_pkg::CMD_X19, ucfd_pkg::CMD_X1B,
			ucfd_pkg::CMD_X1C, ucfd_pkg::CMD_X1D, ucfd_pkg::CMD_X20,
			ucfd_pkg::CMD_X40: begin
				res.frame_end = zero_b;
			end
			ucfd_pkg::CMD_X10: begin
				res.frame_end = zero_b && (n >= ucfd_pkg::POS_W'(3));
			end
			ucfd_pkg::CMD_X22: begin
				res.frame_end = zero_b && (n >= ucfd_pkg::POS_W'(5));
			end
			ucfd_pkg::CMD_X1A: begin
				// rename: first zero ends the old name, second ends the frame
				res.name_done = (n == ucfd_pkg::POS_W'(1)) ? 1'b0 : name_done;
				if (zero_b) begin
					res.frame_end = res.name_done;
					res.name_done = !res.name_done;
				end
			end
			ucfd_pkg::CMD_X13: begin
				// write: four header bytes then the payload
				res.frame_end = (n_ext >= ucfd_pkg::CMP_W'(4)) && (n_ext == write_end);
			end
			default: begin
				res.frame_end   = 1'b1;
				res.bad_command = 1'b1;
			end
		endcase
	end

endmodule

/* src/uart_command_frame_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_command_frame_detector_unit
// Tags received bytes with their frame position and flags frame ends.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle while the receiver does not stall; frame state is updated as the item advances.
// Reset: arst_n clears position, command code, payload length and rename flag
// and empties both pipeline stages.
module uart_command_frame_detector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        op,
	input  logic [7:0]  byte_in,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        accepted,
	output logic [11:0] position,
	output logic [7:0]  byte_out,
	output logic        frame_end,
	output logic [7:0]  command,
	output logic [11:0] frame_length,
	output logic        bad_command,
	output logic        saturated,
	output logic        frame_cleared
);

	logic                valid_s1;
	logic                op_s1;
	logic [7:0]          byte_s1;
	logic                valid_s2;
	ucfd_pkg::pos_t      pos_q;
	logic [7:0]          code_q;
	ucfd_pkg::plen_t     plen_q;
	logic                name_done_q;

	logic                adv;
	logic                is_ctrl;
	logic                lead_zero;
	logic                sat;
	ucfd_pkg::pos_t      n;
	logic [7:0]          code_nx;
	ucfd_pkg::plen_t     plen_nx;
	ucfd_pkg::rule_res_t rule;
	ucfd_pkg::pos_t      pos_nx;
	logic                store;

	// handshake
	assign adv          = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready   = !valid_s1 || adv;
	assign result_valid = valid_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1   <= op;
			byte_s1 <= byte_in;
		end
	end

	// byte classification and next state
	assign is_ctrl   = (op_s1 == ucfd_pkg::OP_CONTROL);
	assign lead_zero = (pos_q == '0) && (byte_s1 == 8'h00);
	assign store     = !is_ctrl && !lead_zero;
	assign sat       = (pos_q == ucfd_pkg::POS_W'(ucfd_pkg::RX_BUFFER_DEPTH - 1));
	assign n         = sat ? pos_q : pos_q + ucfd_pkg::POS_W'(1);
	assign code_nx   = (pos_q == '0) ? byte_s1 : code_q;

	always_comb begin
		plen_nx = plen_q;
		if (pos_q == ucfd_pkg::POS_W'(2)) begin
			plen_nx[7:0] = byte_s1;
		end else if (pos_q == ucfd_pkg::POS_W'(3)) begin
			plen_nx[15:8] = byte_s1;
		end
	end

	ucfd_rules u_rules (
		.code      (code_nx),
		.n         (n),
		.byte_in   (byte_s1),
		.plen      (plen_nx),
		.name_done (name_done_q),
		.res       (rule)
	);

	always_comb begin
		if (is_ctrl) begin
			pos_nx = byte_s1[ucfd_pkg::CLEAR_BIT] ? '0 : pos_q;
		end else if (lead_zero) begin
			pos_nx = pos_q;
		end else begin
			pos_nx = rule.frame_end ? '0 : n;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			code_q      <= '0;
			plen_q      <= '0;
			name_done_q <= 1'b0;
		end else if (adv) begin
			pos_q <= pos_nx;
			if (store) begin
				code_q      <= code_nx;
				plen_q      <= plen_nx;
				name_done_q <= rule.name_done;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accepted      <= store;
			position      <= store ? ucfd_pkg::to_field(pos_q) : '0;
			byte_out      <= store ? byte_s1 : 8'h00;
			frame_end     <= store && rule.frame_end;
			bad_command   <= store && rule.bad_command;
			saturated     <= store && sat;
			frame_cleared <= is_ctrl && byte_s1[ucfd_pkg::CLEAR_BIT];
			if (is_ctrl) begin
				command      <= (pos_nx != '0) ? code_q : 8'h00;
				frame_length <= ucfd_pkg::to_field(pos_nx);
			end else if (lead_zero) begin
				command      <= 8'h00;
				frame_length <= '0;
			end else begin
				command      <= code_nx;
				frame_length <= ucfd_pkg::to_field(n);
			end
		end
	end

`ifndef SYNTHESIS
	// a frame end only comes with a stored byte
	a_end_stored: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_end |-> accepted)
		else $error("frame end without stored item");

	// an unknown code always ends its frame
	a_bad_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_command |-> frame_end)
		else $error("bad command without frame end");

	// a clearing control write stores nothing
	a_clear_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_cleared |-> !accepted && frame_length == '0)
		else $error("clear reported with stored item or nonzero length");

	// a completed frame returns the position to zero
	a_end_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		adv && store && rule.frame_end |=> pos_q == '0)
		else $error("position not cleared after frame end");
`endif

endmodule

/* verif/uart_command_frame_detector_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_command_frame_detector_unit_tb
// Drives data bytes and control writes into the frame detector and checks
// every tag it returns against a frame tracker kept in the bench. A short
// table covers leading zeros, clears, unknown codes and most command classes.
// Long frames cover an exact-fit write, an oversized write cut by a clear and
// a long zero-ended frame. Random frames then run under three sender/receiver
// stall profiles.
// ----------------------------------------------------------------------------
module uart_command_frame_detector_unit_tb;

	localparam int         DEPTH       = ucfd_pkg::RX_BUFFER_DEPTH;
	localparam int         STALL_LIMIT = 2000;
	localparam int         MAX_REPORTS = 30;
	localparam logic [7:0] CMD_UNKNOWN = 8'hFF;
	localparam logic [7:0] CTRL_CLEAR  = 8'h80;
	localparam logic [7:0] CTRL_KEEP   = 8'h7F;
	localparam logic [7:0] CTRL_ALL    = 8'hFF;
	localparam int         TABLE_N     = 27;

	// per-byte tag returned by the block
	typedef struct packed {
		logic        accepted;
		logic [11:0] position;
		logic [7:0]  byte_out;
		logic        frame_end;
		logic [7:0]  command;
		logic [11:0] frame_length;
		logic        bad_command;
		logic        saturated;
		logic        frame_cleared;
	} tag_t;

	typedef struct {
		logic       op;
		logic [7:0] data;
		bit         typed_tag;
		tag_t       tag;
	} item_t;

	typedef enum int {
		CLS_LEN1, CLS_LEN2, CLS_LEN4, CLS_LEN6, CLS_ZERO, CLS_ZERO3, CLS_ZERO5,
		CLS_NAME, CLS_WRITE, CLS_BAD
	} code_class_t;

	localparam tag_t TAG_NONE  = '0;
	localparam tag_t TAG_CLEAR = '{1'b0, 12'd0, 8'h00, 1'b0, 8'h00, 12'd0,
		1'b0, 1'b0, 1'b1};
	localparam tag_t TAG_BAD   = '{1'b1, 12'd0, CMD_UNKNOWN, 1'b1, CMD_UNKNOWN,
		12'd1, 1'b1, 1'b0, 1'b0};
	localparam tag_t TAG_ONE   = '{1'b1, 12'd0, ucfd_pkg::CMD_X01, 1'b1,
		ucfd_pkg::CMD_X01, 12'd1, 1'b0, 1'b0, 1'b0};

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic        op;
	logic [7:0]  byte_in;
	logic        result_valid;
	logic        result_ready;
	logic        accepted;
	logic [11:0] position;
	logic [7:0]  byte_out;
	logic        frame_end;
	logic [7:0]  command;
	logic [11:0] frame_length;
	logic        bad_command;
	logic        saturated;
	logic        frame_cleared;

	// bench copy of the frame state
	int          frame_pos;
	logic [7:0]  frame_code;
	logic [15:0] write_len;
	bit          name_seen;

	item_t       byte_stream[$];
	tag_t        due_tags[$];
	item_t       cur_item;
	int          errors;
	int          stall_cycles;
	int          snd_idle_pct;
	int          rcv_idle_pct;

	logic [7:0] known_codes[26] = '{ucfd_pkg::CMD_X01, ucfd_pkg::CMD_X02,
		ucfd_pkg::CMD_X03, ucfd_pkg::CMD_X08, ucfd_pkg::CMD_X0C, ucfd_pkg::CMD_X0E,
		ucfd_pkg::CMD_X10, ucfd_pkg::CMD_X11, ucfd_pkg::CMD_X12, ucfd_pkg::CMD_X13,
		ucfd_pkg::CMD_X14, ucfd_pkg::CMD_X15, ucfd_pkg::CMD_X16, ucfd_pkg::CMD_X17,
		ucfd_pkg::CMD_X18, ucfd_pkg::CMD_X19, ucfd_pkg::CMD_X1A, ucfd_pkg::CMD_X1B,
		ucfd_pkg::CMD_X1C, ucfd_pkg::CMD_X1D, ucfd_pkg::CMD_X1E, ucfd_pkg::CMD_X1F,
		ucfd_pkg::CMD_X20, ucfd_pkg::CMD_X21, ucfd_pkg::CMD_X22, ucfd_pkg::CMD_X40};

	// directed rows: typed tags only where they are obvious
	item_t byte_table[TABLE_N] = '{
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b1, TAG_NONE},
		'{ucfd_pkg::OP_CONTROL, CTRL_CLEAR,        1'b1, TAG_CLEAR},
		'{ucfd_pkg::OP_DATA,    CMD_UNKNOWN,       1'b1, TAG_BAD},
		'{ucfd_pkg::OP_DATA,    ucfd_pkg::CMD_X01, 1'b1, TAG_ONE},
		'{ucfd_pkg::OP_DATA,    ucfd_pkg::CMD_X03, 1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'hA5,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    ucfd_pkg::CMD_X16, 1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h41,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_CONTROL, CTRL_KEEP,         1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    ucfd_pkg::CMD_X40, 1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    ucfd_pkg::CMD_X10, 1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    ucfd_pkg::CMD_X1A, 1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h61,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h62,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    ucfd_pkg::CMD_X14, 1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h80,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_CONTROL, CTRL_ALL,          1'b1, TAG_CLEAR},
		'{ucfd_pkg::OP_DATA,    ucfd_pkg::CMD_X13, 1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE},
		'{ucfd_pkg::OP_DATA,    8'h00,             1'b0, TAG_NONE}
	};

	uart_command_frame_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.byte_in      (byte_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.accepted     (accepted),
		.position     (position),
		.byte_out     (byte_out),
		.frame_end    (frame_end),
		.command      (command),
		.frame_length (frame_length),
		.bad_command  (bad_command),
		.saturated    (saturated),
		.frame_cleared(frame_cleared)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// how each command code ends its frame
	function automatic code_class_t code_class(logic [7:0] code);
		case (code)
			ucfd_pkg::CMD_X01, ucfd_pkg::CMD_X02, ucfd_pkg::CMD_X0C, ucfd_pkg::CMD_X1E,
			ucfd_pkg::CMD_X1F:
				return CLS_LEN1;
			ucfd_pkg::CMD_X03, ucfd_pkg::CMD_X08, ucfd_pkg::CMD_X0E, ucfd_pkg::CMD_X11,
			ucfd_pkg::CMD_X15, ucfd_pkg::CMD_X17, ucfd_pkg::CMD_X18:
				return CLS_LEN2;
			ucfd_pkg::CMD_X12, ucfd_pkg::CMD_X21: return CLS_LEN4;
			ucfd_pkg::CMD_X14: return CLS_LEN6;
			ucfd_pkg::CMD_X16, ucfd_pkg::CMD_X19, ucfd_pkg::CMD_X1B, ucfd_pkg::CMD_X1C,
			ucfd_pkg::CMD_X1D, ucfd_pkg::CMD_X20, ucfd_pkg::CMD_X40:
				return CLS_ZERO;
			ucfd_pkg::CMD_X10: return CLS_ZERO3;
			ucfd_pkg::CMD_X22: return CLS_ZERO5;
			ucfd_pkg::CMD_X1A: return CLS_NAME;
			ucfd_pkg::CMD_X13: return CLS_WRITE;
			default: return CLS_BAD;
		endcase
	endfunction

	// tag one byte or control write and advance the bench frame state
	function automatic tag_t tag_byte(logic o, logic [7:0] b);
		tag_t t;
		int   p;
		int   n;
		bit   fin;
		t   = '0;
		fin = 1'b0;
		if (o == ucfd_pkg::OP_CONTROL) begin
			if (b[ucfd_pkg::CLEAR_BIT]) begin
				frame_pos       = 0;
				t.frame_cleared = 1'b1;
			end
			t.command      = (frame_pos != 0) ? frame_code : 8'h00;
			t.frame_length = frame_pos[11:0];
			return t;
		end
		p = frame_pos;
		// leading zero is dropped
		if (p == 0 && b == 8'h00)
			return t;
		if (p == 0)
			frame_code = b;
		else if (p == 2)
			write_len[7:0] = b;
		else if (p == 3)
			write_len[15:8] = b;
		if (p < DEPTH - 1) begin
			n = p + 1;
		end else begin
			n           = p;
			t.saturated = 1'b1;
		end
		case (code_class(frame_code))
			CLS_LEN1:  fin = 1'b1;
			CLS_LEN2:  fin = (n == 2);
			CLS_LEN4:  fin = (n == 4);
			CLS_LEN6:  fin = (n == 6);
			CLS_ZERO:  fin = (b == 8'h00);
			CLS_ZERO3: fin = (b == 8'h00) && (n >= 3);
			CLS_ZERO5: fin = (b == 8'h00) && (n >= 5);
			CLS_NAME: begin
				if (n == 1)
					name_seen = 1'b0;
				if (b == 8'h00) begin
					fin       = name_seen;
					name_seen = !name_seen;
				end
			end
			CLS_WRITE: fin = (n >= 4) && (n == 4 + int'(write_len));
			default: begin
				fin           = 1'b1;
				t.bad_command = 1'b1;
			end
		endcase
		t.accepted     = 1'b1;
		t.position     = p[11:0];
		t.byte_out     = b;
		t.command      = frame_code;
		t.frame_length = n[11:0];
		t.frame_end    = fin;
		frame_pos      = fin ? 0 : n;
		return t;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
					want, got);
		end
	endtask

	// watch both handshakes: predict on input, check on output
	always @(posedge clk) begin
		tag_t got;
		tag_t want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				want = tag_byte(cur_item.op, cur_item.data);
				if (cur_item.typed_tag)
					want = cur_item.tag;
				due_tags = {due_tags, want};
			end
			if (result_valid && result_ready) begin
				got = '{accepted, position, byte_out, frame_end, command, frame_length,
					bad_command, saturated, frame_cleared};
				if (due_tags.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected tag, expected none, actual %h", $time,
							got);
				end else begin
					want = due_tags.pop_front();
					check_field("accepted", want.accepted, got.accepted);
					check_field("position", want.position, got.position);
					check_field("byte_out", want.byte_out, got.byte_out);
					check_field("frame_end", want.frame_end, got.frame_end);
					check_field("command", want.command, got.command);
					check_field("frame_length", want.frame_length, got.frame_length);
					check_field("bad_command", want.bad_command, got.bad_command);
					check_field("saturated", want.saturated, got.saturated);
					check_field("frame_cleared", want.frame_cleared, got.frame_cleared);
				end
			end
			// watchdog on handshake progress
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("uart_command_frame_detector_unit_tb failed");
				$finish;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (arst_n)
			result_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	task automatic add_item(logic o, logic [7:0] b);
		item_t it;
		it.op        = o;
		it.data      = b;
		it.typed_tag = 1'b0;
		it.tag       = '0;
		byte_stream  = {byte_stream, it};
	endtask

	// send queued items, one handshake each, with random sender gaps
	task automatic send_stream();
		item_t it;
		while (byte_stream.size() > 0) begin
			it = byte_stream.pop_front();
			while ($urandom_range(0, 99) < snd_idle_pct) begin
				item_valid <= 1'b0;
				@(negedge clk);
			end
			cur_item   = it;
			item_valid <= 1'b1;
			op         <= it.op;
			byte_in    <= it.data;
			do
				@(posedge clk);
			while (!item_ready);
			@(negedge clk);
		end
		item_valid <= 1'b0;
	endtask

	// hold the sender until every tag has come back
	task automatic drain();
		while (due_tags.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// one long frame: code, header bytes, body, then a closing zero or clear
	task automatic add_long_frame(logic [7:0] code, logic [7:0] len_lo,
		logic [7:0] len_hi, int body, bit zero_end);
		add_item(ucfd_pkg::OP_DATA, code);
		add_item(ucfd_pkg::OP_DATA, 8'($urandom_range(1, 255)));
		add_item(ucfd_pkg::OP_DATA, len_lo);
		add_item(ucfd_pkg::OP_DATA, len_hi);
		for (int i = 0; i < body; i++)
			add_item(ucfd_pkg::OP_DATA, 8'($urandom_range(1, 255)));
		if (zero_end)
			add_item(ucfd_pkg::OP_DATA, 8'h00);
		else
			add_item(ucfd_pkg::OP_CONTROL, CTRL_CLEAR | 8'($urandom_range(0, 127)));
	endtask

	// one random frame, mostly well formed
	task automatic add_frame();
		int          kind;
		int          len;
		logic [7:0]  code;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			// loose noise
			add_item(1'($urandom_range(0, 1)), 8'($urandom));
		end else if (kind < 12) begin
			// leading zeros
			repeat ($urandom_range(1, 3))
				add_item(ucfd_pkg::OP_DATA, 8'h00);
		end else if (kind < 17) begin
			// broken frame cut short by a clear
			add_item(ucfd_pkg::OP_DATA, known_codes[5'($urandom_range(0, 25))]);
			repeat ($urandom_range(0, 4))
				add_item(ucfd_pkg::OP_DATA, 8'($urandom));
			add_item(ucfd_pkg::OP_CONTROL, CTRL_CLEAR | 8'($urandom_range(0, 127)));
		end else begin
			if ($urandom_range(0, 9) == 0)
				code = 8'($urandom_range(1, 255));
			else
				code = known_codes[5'($urandom_range(0, 25))];
			add_item(ucfd_pkg::OP_DATA, code);
			// control write without clear inside the frame
			if ($urandom_range(0, 9) == 0)
				add_item(ucfd_pkg::OP_CONTROL, 8'($urandom_range(0, 127)));
			case (code_class(code))
				CLS_LEN2: add_item(ucfd_pkg::OP_DATA, 8'($urandom));
				CLS_LEN4: repeat (3) add_item(ucfd_pkg::OP_DATA, 8'($urandom));
				CLS_LEN6: repeat (5) add_item(ucfd_pkg::OP_DATA, 8'($urandom));
				CLS_ZERO, CLS_ZERO3, CLS_ZERO5: begin
					len = $urandom_range(3, 8);
					if ($urandom_range(0, 3) == 0)
						len = $urandom_range(0, 8);
					repeat (len) add_item(ucfd_pkg::OP_DATA, 8'($urandom_range(1, 255)));
					add_item(ucfd_pkg::OP_DATA, 8'h00);
				end
				CLS_NAME: begin
					repeat ($urandom_range(0, 5))
						add_item(ucfd_pkg::OP_DATA, 8'($urandom_range(1, 255)));
					add_item(ucfd_pkg::OP_DATA, 8'h00);
					repeat ($urandom_range(0, 5))
						add_item(ucfd_pkg::OP_DATA, 8'($urandom_range(1, 255)));
					add_item(ucfd_pkg::OP_DATA, 8'h00);
				end
				CLS_WRITE: begin
					len = $urandom_range(0, 12);
					add_item(ucfd_pkg::OP_DATA, 8'($urandom));
					add_item(ucfd_pkg::OP_DATA, 8'(len));
					add_item(ucfd_pkg::OP_DATA, 8'h00);
					repeat (len) add_item(ucfd_pkg::OP_DATA, 8'($urandom));
				end
				default: ;
			endcase
		end
	endtask

	initial begin
		int phase;
		int sent;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		op           = ucfd_pkg::OP_DATA;
		byte_in      = 8'h00;
		result_ready = 1'b0;
		errors       = 0;
		stall_cycles = 0;
		frame_pos    = 0;
		frame_code   = 8'h00;
		write_len    = 16'h0000;
		name_seen    = 1'b0;
		snd_idle_pct = 10;
		rcv_idle_pct = 61;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (byte_table[i])
			byte_stream = {byte_stream, byte_table[i]};
		send_stream();
		drain();

		// long frames: exact fit write, oversized write, long zero-ended frame
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		add_long_frame(ucfd_pkg::CMD_X13, 8'h40, 8'h00, 64, 1'b0);
		add_long_frame(ucfd_pkg::CMD_X13, 8'hFF, 8'hFF, 32, 1'b0);
		add_long_frame(ucfd_pkg::CMD_X16, 8'h5A, 8'hA5, 40, 1'b1);
		send_stream();
		drain();

		// random frames under three stall profiles
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin snd_idle_pct = 10; rcv_idle_pct = 61; end
				1: begin snd_idle_pct = 61; rcv_idle_pct = 10; end
				default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
			endcase
			sent = 0;
			while (sent < 190) begin
				add_frame();
				sent = byte_stream.size();
			end
			send_stream();
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("uart_command_frame_detector_unit_tb passed");
		else
			$display("uart_command_frame_detector_unit_tb failed");
		$finish;
	end

endmodule

/* uart_command_frame_detector_unit.f */
src/ucfd_pkg.sv
src/ucfd_rules.sv
src/uart_command_frame_detector_unit.sv
verif/uart_command_frame_detector_unit_tb.sv
